### hdl/hmtp_pkg.sv
// ============================================================================
// hmtp_pkg - shared types and constants for the height-map text parser
// Payload structs, parser phases, controller states, command/status bundles.
// ============================================================================
package hmtp_pkg;

	// Map limits and counter widths
	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int CNT_W       = 11;
	localparam int IDX_W       = 10;

	// Projection and color constants
	localparam logic signed [17:0] COS30_Q16 = 18'sd56756;
	localparam logic [31:0]        WHITE     = 32'h00FF_FFFF;

	// Result kinds
	localparam logic [1:0] KIND_POINT    = 2'd0;
	localparam logic [1:0] KIND_MISMATCH = 2'd1;
	localparam logic [1:0] KIND_DONE     = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_SCALE    = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_X = 2'd1;
	localparam logic [1:0] CFG_ORIGIN_Y = 2'd2;

	// Characters
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [9:0]         column_index;
		logic [9:0]         row_index;
		logic signed [15:0] height;
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic [31:0]        color;
		logic [10:0]        point_count;
		logic [10:0]        row_count;
		logic               last;
	} result_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_PIECE0,
		PH_PRE,
		PH_COLOR,
		PH_TAIL
	} phase_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_DECODE,
		C_PROJ1,
		C_PROJ2,
		C_POINT,
		C_CLOSE,
		C_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic feed;
		logic proj1;
		logic proj2;
		logic emit_point;
		logic close_row;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic eoi;
		logic failed;
		logic is_nl;
		logic is_sp;
		logic tok_pending;
		logic line_open;
		logic mismatch;
		logic out_free;
	} dp_status_t;

	// Hex digit decode: bit 4 set flags a non-hex character
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end else begin
			r = 5'h10;
		end
		return r;
	endfunction

endpackage

### hdl/heightmap_text_parser_isometric_top.sv
// ============================================================================
// heightmap_text_parser_isometric_top - map text parser with iso projection
// Parses map text bytes into projected points, row checks and a size report.
// ============================================================================
// Usage:
//   item channel (item_valid/item_stall/item) takes one text byte per beat,
//   or an end-of-input beat that closes the pending token and row and then
//   reports the map size. result channel (result_valid/result_stall/result)
//   gives points, a row-length mismatch, or the done report; last marks the
//   final result caused by one input beat. cfg_valid/cfg_ready/cfg_index/
//   cfg_data write scale, origin_x and origin_y; cfg_ready is always high.
// Sequence:
//   A plain byte passes through the decode state only. A byte that ends a
//   token runs two projection multiply stages (PROJ1, PROJ2) and then the
//   POINT state, which loads its point. Closing a row adds the CLOSE state,
//   the done report DONE. No new byte is taken until the controller is idle.
// Reset:
//   arst_n clears the parser and restores scale 20, origin 960/270.
// Stall:
//   A result waits in the output register while the next byte is taken;
//   the controller holds only when it must load a new result into it.
// ============================================================================
module heightmap_text_parser_isometric_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  hmtp_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output hmtp_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data
);

	hmtp_pkg::dp_cmd_t    cmd;
	hmtp_pkg::dp_status_t status;
	logic                 cfg_we;

	// Registers accept writes at any time
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	hmtp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	hmtp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

endmodule

### hdl/hmtp_ctrl.sv
// ============================================================================
// hmtp_ctrl - sequencing controller for the height-map text parser
// Steps one text byte through decode, projection, row close and report.
// ============================================================================
module hmtp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  hmtp_pkg::dp_status_t  status,
	output hmtp_pkg::dp_cmd_t     cmd
);

	hmtp_pkg::ctrl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hmtp_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hmtp_pkg::C_IDLE: begin
				if (item_valid) state_d = hmtp_pkg::C_DECODE;
			end
			hmtp_pkg::C_DECODE: begin
				priority if (status.eoi) begin
					if (status.failed) state_d = hmtp_pkg::C_DONE;
					else if (status.tok_pending) state_d = hmtp_pkg::C_PROJ1;
					else if (status.line_open) state_d = hmtp_pkg::C_CLOSE;
					else state_d = hmtp_pkg::C_DONE;
				end else if (status.failed) begin
					state_d = hmtp_pkg::C_IDLE;
				end else if ((status.is_nl || status.is_sp) && status.tok_pending) begin
					state_d = hmtp_pkg::C_PROJ1;
				end else if (status.is_nl) begin
					state_d = hmtp_pkg::C_CLOSE;
				end else begin
					state_d = hmtp_pkg::C_IDLE;
				end
			end
			hmtp_pkg::C_PROJ1: state_d = hmtp_pkg::C_PROJ2;
			hmtp_pkg::C_PROJ2: state_d = hmtp_pkg::C_POINT;
			hmtp_pkg::C_POINT: begin
				if (status.out_free) begin
					if (status.eoi || status.is_nl) state_d = hmtp_pkg::C_CLOSE;
					else state_d = hmtp_pkg::C_IDLE;
				end
			end
			hmtp_pkg::C_CLOSE: begin
				if (status.out_free || !status.mismatch) begin
					if (status.eoi) state_d = hmtp_pkg::C_DONE;
					else state_d = hmtp_pkg::C_IDLE;
				end
			end
			hmtp_pkg::C_DONE: begin
				if (status.out_free || status.failed) state_d = hmtp_pkg::C_IDLE;
			end
			default: state_d = hmtp_pkg::C_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd        = '0;
		item_stall = (state_q != hmtp_pkg::C_IDLE);
		unique case (state_q)
			hmtp_pkg::C_IDLE: cmd.load = item_valid;
			hmtp_pkg::C_DECODE: begin
				cmd.feed = !status.eoi && !status.failed && !status.is_nl
					&& !(status.is_sp && status.tok_pending);
			end
			hmtp_pkg::C_PROJ1: cmd.proj1 = 1'b1;
			hmtp_pkg::C_PROJ2: cmd.proj2 = 1'b1;
			hmtp_pkg::C_POINT: cmd.emit_point = status.out_free;
			hmtp_pkg::C_CLOSE: cmd.close_row = status.out_free || !status.mismatch;
			hmtp_pkg::C_DONE: cmd.finish = status.out_free || status.failed;
			default: cmd = '0;
		endcase
	end

endmodule

### hdl/hmtp_dp.sv
// ============================================================================
// hmtp_dp - datapath for the height-map text parser
// Token and row state, configuration registers, projection arithmetic
// and the result register.
// ============================================================================
module hmtp_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hmtp_pkg::item_t       item,
	input  hmtp_pkg::dp_cmd_t     cmd,
	output hmtp_pkg::dp_status_t  status,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [11:0]           cfg_data,
	output logic                  result_valid,
	output hmtp_pkg::result_t     result,
	input  logic                  result_stall
);

	localparam int CW = hmtp_pkg::CNT_W;
	localparam int IW = hmtp_pkg::IDX_W;

	// Latched input beat
	logic [7:0] byte_q;
	logic       eoi_q;

	// Configuration
	logic [7:0]  scale_q;
	logic [11:0] origin_x_q;
	logic [11:0] origin_y_q;

	// Parser state
	hmtp_pkg::phase_t phase_q;
	logic [15:0]      height_acc_q;
	logic             negative_q;
	logic [31:0]      color_acc_q;
	logic [1:0]       prefix_skip_q;
	logic             color_present_q;
	logic [CW-1:0]    col_cnt_q;
	logic [CW-1:0]    row_num_q;
	logic [CW-1:0]    exp_width_q;
	logic             failed_q;
	logic             line_open_q;

	// Projection pipeline
	logic signed [20:0] m1_s1;
	logic signed [27:0] p_s1;
	logic signed [37:0] m2_s2;
	logic signed [28:0] q_s2;

	// Result register
	logic              res_valid_q;
	hmtp_pkg::result_t res_q;

	// Byte classes
	logic       is_digit, is_ws, is_nl, is_sp, is_comma;
	logic [3:0] dval;
	logic [4:0] hex;
	assign is_digit = (byte_q >= hmtp_pkg::CH_ZERO) && (byte_q <= hmtp_pkg::CH_NINE);
	assign is_ws    = (byte_q >= hmtp_pkg::CH_TAB) && (byte_q <= hmtp_pkg::CH_CR);
	assign is_nl    = (byte_q == hmtp_pkg::CH_NL);
	assign is_sp    = (byte_q == hmtp_pkg::CH_SP);
	assign is_comma = (byte_q == hmtp_pkg::CH_COMMA);
	assign dval     = 4'(byte_q - hmtp_pkg::CH_ZERO);
	assign hex      = hmtp_pkg::hex_value(byte_q);

	// Saturated height of the pending token
	logic [15:0]        mag_neg;
	logic [15:0]        mag_pos;
	logic signed [15:0] height_d;
	assign mag_neg  = (height_acc_q > 16'd32768) ? 16'd32768 : height_acc_q;
	assign mag_pos  = (height_acc_q > 16'd32767) ? 16'd32767 : height_acc_q;
	assign height_d = negative_q ? $signed(16'(~mag_neg + 16'd1)) : $signed(mag_pos);

	// Row bookkeeping
	logic          col_in_range, row_in_range;
	logic [CW-1:0] col_next, row_next;
	logic          mismatch, mismatch_after;
	assign col_in_range   = col_cnt_q < CW'(hmtp_pkg::MAX_COLUMNS);
	assign row_in_range   = row_num_q < CW'(hmtp_pkg::MAX_ROWS);
	assign col_next       = col_in_range ? col_cnt_q + CW'(1) : col_cnt_q;
	assign row_next       = row_in_range ? row_num_q + CW'(1) : row_num_q;
	assign mismatch       = (exp_width_q != '0) && (col_cnt_q != exp_width_q);
	assign mismatch_after = (exp_width_q != '0) && (col_next != exp_width_q);

	// Status to the controller
	assign status.eoi         = eoi_q;
	assign status.failed      = failed_q;
	assign status.is_nl       = is_nl;
	assign status.is_sp       = is_sp;
	assign status.tok_pending = (phase_q != hmtp_pkg::PH_IDLE);
	assign status.line_open   = line_open_q;
	assign status.mismatch    = mismatch;
	assign status.out_free    = !res_valid_q || !result_stall;

	// Ordinary byte: next token state
	hmtp_pkg::phase_t phase_d;
	logic [15:0]      height_acc_d;
	logic             negative_d;
	logic [31:0]      color_acc_d;
	logic [1:0]       prefix_skip_d;
	logic             color_present_d;
	logic [19:0]      acc_mul;
	assign acc_mul = 20'(height_acc_q) * 20'd10 + 20'(dval);

	always_comb begin
		phase_d         = phase_q;
		height_acc_d    = height_acc_q;
		negative_d      = negative_q;
		color_acc_d     = color_acc_q;
		prefix_skip_d   = prefix_skip_q;
		color_present_d = color_present_q;
		if (!is_sp) begin
			unique case (phase_q)
				hmtp_pkg::PH_IDLE, hmtp_pkg::PH_LEAD: begin
					priority if (is_ws) begin
						phase_d = hmtp_pkg::PH_LEAD;
					end else if (byte_q == hmtp_pkg::CH_PLUS
						|| byte_q == hmtp_pkg::CH_MINUS) begin
						negative_d = (byte_q == hmtp_pkg::CH_MINUS);
						phase_d    = hmtp_pkg::PH_SIGN;
					end else if (is_digit) begin
						height_acc_d = 16'(dval);
						phase_d      = hmtp_pkg::PH_DIGITS;
					end else if (is_comma) begin
						phase_d = (phase_q == hmtp_pkg::PH_IDLE) ? hmtp_pkg::PH_PRE
							: hmtp_pkg::PH_COLOR;
					end else begin
						phase_d = hmtp_pkg::PH_PIECE0;
					end
				end
				hmtp_pkg::PH_SIGN, hmtp_pkg::PH_DIGITS: begin
					if (is_digit) begin
						height_acc_d = (acc_mul > 20'd32768) ? 16'd32768 : acc_mul[15:0];
						phase_d      = hmtp_pkg::PH_DIGITS;
					end else begin
						phase_d = is_comma ? hmtp_pkg::PH_COLOR : hmtp_pkg::PH_PIECE0;
					end
				end
				hmtp_pkg::PH_PIECE0: begin
					if (is_comma) phase_d = hmtp_pkg::PH_COLOR;
				end
				hmtp_pkg::PH_PRE: begin
					if (!is_comma) phase_d = hmtp_pkg::PH_PIECE0;
				end
				hmtp_pkg::PH_COLOR: begin
					if (is_comma) begin
						if (color_present_q) phase_d = hmtp_pkg::PH_TAIL;
					end else begin
						color_present_d = 1'b1;
						if (prefix_skip_q != 2'd2) begin
							prefix_skip_d = prefix_skip_q + 2'd1;
						end else if (hex[4]) begin
							color_acc_d = '1;
						end else begin
							color_acc_d = {color_acc_q[27:0], hex[3:0]};
						end
					end
				end
				hmtp_pkg::PH_TAIL: phase_d = phase_q;
				default: phase_d = phase_q;
			endcase
		end
	end

	// Projection stage 1: column/row products with scale
	logic signed [11:0] col_s, row_s, diff;
	logic signed [11:0] crsum;
	logic signed [18:0] s_d;
	logic signed [8:0]  scale_s;
	logic signed [20:0] m1_d;
	logic signed [27:0] p_d;
	assign col_s   = $signed({2'b00, col_cnt_q[IW-1:0]});
	assign row_s   = $signed({2'b00, row_num_q[IW-1:0]});
	assign diff    = col_s - row_s;
	assign crsum   = col_s + row_s;
	assign s_d     = 19'(crsum) - 19'($signed({height_d, 1'b0}));
	assign scale_s = $signed({1'b0, scale_q});
	assign m1_d    = 21'(diff) * 21'(scale_s);
	assign p_d     = 28'(s_d) * 28'(scale_s);

	// Projection stage 2: cosine product and y offset
	logic signed [37:0] m2_d;
	logic signed [28:0] q_d;
	assign m2_d = 38'(m1_s1) * 38'(hmtp_pkg::COS30_Q16);
	assign q_d  = 29'(p_s1) + $signed({16'd0, origin_y_q, 1'b0});

	always_ff @(posedge clk) begin
		if (cmd.proj1) begin
			m1_s1 <= m1_d;
			p_s1  <= p_d;
		end
		if (cmd.proj2) begin
			m2_s2 <= m2_d;
			q_s2  <= q_d;
		end
	end

	// Final offset and truncation toward zero
	logic signed [37:0] n_x;
	logic signed [37:0] sx_full;
	logic signed [28:0] sy_full;
	assign n_x     = m2_s2 + $signed({10'd0, origin_x_q, 16'd0});
	assign sx_full = n_x[37] ? ((n_x + 38'sd65535) >>> 16) : (n_x >>> 16);
	assign sy_full = q_s2[28] ? ((q_s2 + 29'sd1) >>> 1) : (q_s2 >>> 1);

	// Result candidates
	hmtp_pkg::result_t pt_res, mm_res, done_res;
	always_comb begin
		pt_res              = '0;
		pt_res.kind         = hmtp_pkg::KIND_POINT;
		pt_res.column_index = col_cnt_q[IW-1:0];
		pt_res.row_index    = row_num_q[IW-1:0];
		pt_res.height       = height_d;
		pt_res.screen_x     = sx_full[31:0];
		pt_res.screen_y     = 32'(sy_full);
		pt_res.color        = color_present_q ? color_acc_q : hmtp_pkg::WHITE;
		pt_res.last         = !eoi_q && !(is_nl && mismatch_after);

		mm_res             = '0;
		mm_res.kind        = hmtp_pkg::KIND_MISMATCH;
		mm_res.row_index   = row_num_q[IW-1:0];
		mm_res.point_count = col_cnt_q;
		mm_res.last        = 1'b1;

		done_res             = '0;
		done_res.kind        = hmtp_pkg::KIND_DONE;
		done_res.point_count = exp_width_q;
		done_res.row_count   = row_num_q;
		done_res.last        = 1'b1;
	end

	// Latch the input beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= item.text_byte;
			eoi_q  <= item.end_of_input;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= 8'd20;
			origin_x_q <= 12'd960;
			origin_y_q <= 12'd270;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hmtp_pkg::CFG_SCALE:    scale_q    <= cfg_data[7:0];
				hmtp_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data;
				hmtp_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Parser and row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= hmtp_pkg::PH_IDLE;
			height_acc_q    <= '0;
			negative_q      <= 1'b0;
			color_acc_q     <= '0;
			prefix_skip_q   <= '0;
			color_present_q <= 1'b0;
			col_cnt_q       <= '0;
			row_num_q       <= '0;
			exp_width_q     <= '0;
			failed_q        <= 1'b0;
			line_open_q     <= 1'b0;
		end else begin
			priority if (cmd.finish) begin
				// clear the whole map
				phase_q         <= hmtp_pkg::PH_IDLE;
				height_acc_q    <= '0;
				negative_q      <= 1'b0;
				color_acc_q     <= '0;
				prefix_skip_q   <= '0;
				color_present_q <= 1'b0;
				col_cnt_q       <= '0;
				row_num_q       <= '0;
				exp_width_q     <= '0;
				failed_q        <= 1'b0;
				line_open_q     <= 1'b0;
			end else if (cmd.emit_point) begin
				// advance column, drop token
				col_cnt_q       <= col_next;
				phase_q         <= hmtp_pkg::PH_IDLE;
				height_acc_q    <= '0;
				negative_q      <= 1'b0;
				color_acc_q     <= '0;
				prefix_skip_q   <= '0;
				color_present_q <= 1'b0;
			end else if (cmd.close_row) begin
				if (mismatch) begin
					failed_q <= 1'b1;
				end else if (row_num_q == '0) begin
					exp_width_q <= col_cnt_q;
				end
				row_num_q   <= row_next;
				col_cnt_q   <= '0;
				line_open_q <= 1'b0;
			end else if (cmd.feed) begin
				line_open_q     <= 1'b1;
				phase_q         <= phase_d;
				height_acc_q    <= height_acc_d;
				negative_q      <= negative_d;
				color_acc_q     <= color_acc_d;
				prefix_skip_q   <= prefix_skip_d;
				color_present_q <= color_present_d;
			end
		end
	end

	// Result register: load on emit, release when taken
	logic res_load;
	assign res_load = (cmd.emit_point && col_in_range && row_in_range)
		|| (cmd.close_row && mismatch)
		|| (cmd.finish && !failed_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			priority if (cmd.emit_point) res_q <= pt_res;
			else if (cmd.close_row) res_q <= mm_res;
			else res_q <= done_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
